>>> hdl/mslfo_pkg.sv
// ----------------------------------------------------------------------------
// mslfo_pkg
// Shared types and constants for the multi-shape LFO core.
// ----------------------------------------------------------------------------
package mslfo_pkg;

  localparam int SINE_DEPTH_DEFAULT = 256;

  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int SHAPE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int S_DATA_W  = 64;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_RANDOM   = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_NOTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd2;

  localparam logic [SAMPLE_W-1:0] DEPTH_RESET = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROM,
    ST_SHAPE,
    ST_SCALE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                      go;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

>>> hdl/multi_shape_lfo_core.sv
// ----------------------------------------------------------------------------
// multi_shape_lfo_core
// Multi-shape LFO: Q0.32 phase accumulator, sine/square/random/triangle shapes.
// ----------------------------------------------------------------------------
// A tick beat (tuser 0) drops s_tready after acceptance and walks the states
// MUL, ROM, SHAPE, SCALE and FIN before the core is ready again. One shared
// multiplier is used first for the sine table index or the random
// interpolation, then for the depth scaling, with a registered sine table
// read between; a held result stalls the last step. A note-start beat
// (tuser 1) leaves the core idle and produces no output beat. The output
// register lets the next beat be accepted while a result waits.
module multi_shape_lfo_core #(
  parameter int SINE_TABLE_DEPTH = mslfo_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mslfo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mslfo_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // start_phase[31:0], random_first[47:32], random_fresh[63:48]
  input  logic [mslfo_pkg::S_DATA_W-1:0]    s_tdata,
  // operation[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // lfo_value[15:0]
  output logic [mslfo_pkg::SAMPLE_W-1:0]    m_tdata,
  // phase_wrapped[0]
  output logic                              m_tuser
);
  import mslfo_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);

  state_t state, state_next;

  logic [SHAPE_W-1:0]         lfo_shape;
  logic [PHASE_W-1:0]         phase_increment;
  logic [SAMPLE_W-1:0]        lfo_depth;
  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] held_random;
  logic signed [SAMPLE_W-1:0] next_random;
  logic signed [SAMPLE_W-1:0] fresh;
  logic signed [MUL_B_W-1:0]  shaped;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;
  logic [AW-1:0]             rom_addr;
  logic [15:0]               rom_data;

  logic                      accept;
  logic                      fin_fire;
  logic signed [SAMPLE_W:0]  diff;
  logic [AW-1:0]             sine_idx;
  logic [PHASE_W-1:0]        tri_dist;
  logic signed [MUL_B_W-1:0] sine_val;
  logic signed [MUL_B_W-1:0] shaped_next;
  logic signed [MUL_P_W-1:0] rounded;
  logic signed [35:0]        scaled;
  logic [SAMPLE_W-1:0]       sat_value;
  logic [PHASE_W:0]          phase_sum;

  mslfo_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  mslfo_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .AW               (AW)
  ) u_rom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_data)
  );

  assign accept = s_tvalid && s_tready;
  assign diff   = {next_random[SAMPLE_W-1], next_random}
                - {held_random[SAMPLE_W-1], held_random};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && s_tuser == OP_TICK) state_next = ST_MUL;
      ST_MUL:   state_next = ST_ROM;
      ST_ROM:   state_next = ST_SHAPE;
      ST_SHAPE: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_FIN;
      ST_FIN:   if (fin_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = 1'b0;
    fin_fire    = 1'b0;
    mul_req.go  = 1'b0;
    mul_req.a   = $signed({3'b000, phase[29:0]});
    mul_req.b   = MUL_B_W'(SINE_TABLE_DEPTH);
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MUL: begin
        mul_req.go = 1'b1;
        if (lfo_shape == SHAPE_RANDOM) begin
          mul_req.a = $signed({1'b0, phase});
          mul_req.b = {diff[SAMPLE_W], diff};
        end
      end
      ST_SCALE: begin
        mul_req.go = 1'b1;
        mul_req.a  = $signed({{(MUL_A_W-SAMPLE_W){1'b0}}, lfo_depth});
        mul_req.b  = shaped;
      end
      ST_FIN: fin_fire = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // sine index from the product, mirrored on odd quadrants
  assign sine_idx = prod[30 +: AW];
  assign rom_addr = phase[30] ? AW'(SINE_TABLE_DEPTH - 1) - sine_idx : sine_idx;

  assign tri_dist = phase[31] ? {1'b0, phase[30:0]} : 32'h8000_0000 - phase;
  assign sine_val = phase[31] ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});

  always_comb begin
    case (lfo_shape)
      SHAPE_SINE:     shaped_next = sine_val;
      SHAPE_SQUARE:   shaped_next = phase[31] ? -18'sd32768 : 18'sd32768;
      SHAPE_RANDOM:   shaped_next = MUL_B_W'(held_random) + prod[49:32];
      SHAPE_TRIANGLE: shaped_next = 18'sd32768 - $signed({1'b0, tri_dist[31:15]});
      default:        shaped_next = '0;
    endcase
  end

  assign rounded   = prod + MUL_P_W'(16384);
  assign scaled    = rounded[MUL_P_W-1:15];
  assign sat_value = (scaled > 36'sd32767)  ? 16'h7FFF :
                     (scaled < -36'sd32768) ? 16'h8000 : scaled[15:0];
  assign phase_sum = {1'b0, phase} + {1'b0, phase_increment};

  always_ff @(posedge clk) begin
    if (state == ST_SHAPE) shaped <= shaped_next;
    if (accept) fresh <= s_tdata[63:48];
    if (fin_fire) begin
      m_tdata <= sat_value;
      m_tuser <= phase_sum[PHASE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      lfo_shape       <= SHAPE_SINE;
      phase_increment <= '0;
      lfo_depth       <= DEPTH_RESET;
      phase           <= '0;
      held_random     <= '0;
      next_random     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SHAPE: lfo_shape       <= cfg_data[SHAPE_W-1:0];
          REG_INC:   phase_increment <= cfg_data[PHASE_W-1:0];
          REG_DEPTH: lfo_depth       <= cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (accept && s_tuser == OP_NOTE) begin
        phase       <= s_tdata[31:0];
        held_random <= s_tdata[47:32];
        next_random <= s_tdata[63:48];
      end
      if (fin_fire) begin
        phase <= phase_sum[PHASE_W-1:0];
        if (phase_sum[PHASE_W]) begin
          held_random <= next_random;
          next_random <= fresh;
        end
      end
      if (fin_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/mslfo_sine_rom.sv
// ----------------------------------------------------------------------------
// mslfo_sine_rom
// Quarter-wave sine table, contents fixed at elaboration, registered read.
// ----------------------------------------------------------------------------
module mslfo_sine_rom #(
  parameter int SINE_TABLE_DEPTH = mslfo_pkg::SINE_DEPTH_DEFAULT,
  parameter int AW               = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  output logic [15:0]   rd_data
);
  import mslfo_pkg::*;

  function automatic logic [15:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned entry;
    x = (HALF_PI_Q30 * (2 * longint'(idx) + 1)) / (2 * SINE_TABLE_DEPTH);
    term = x;
    sum  = x;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    entry = (sum * 32768 + (64'd1 << 29)) >> 30;
    if (entry > 32768) begin
      entry = 32768;
    end
    return entry[15:0];
  endfunction

  logic [15:0] rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = sine_entry(g);
  end

  always_ff @(posedge clk) begin
    rd_data <= rom[addr];
  end

endmodule

>>> hdl/mslfo_mul.sv
// ----------------------------------------------------------------------------
// mslfo_mul
// Shared signed 33x18 multiplier with registered product and load enable.
// ----------------------------------------------------------------------------
module mslfo_mul (
  input  logic                                clk,
  input  mslfo_pkg::mul_req_t                 req,
  output logic signed [mslfo_pkg::MUL_P_W-1:0] prod
);
  import mslfo_pkg::*;

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= req.a * req.b;
    end
  end

endmodule

>>> hdl/mslfo_checker.sv
// ----------------------------------------------------------------------------
// mslfo_checker
// Port-level checks for the multi-shape LFO core, bound to the top level.
// ----------------------------------------------------------------------------
module mslfo_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic s_tuser,
  input logic m_tvalid,
  input logic m_tready,
  input logic [15:0] m_tdata
);
  import mslfo_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("not idle after reset");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_TICK) |=> !s_tready)
    else $error("ready right after tick beat");

  a_note_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_NOTE) |=> s_tready)
    else $error("note start did not return to ready");

  a_result_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed");

endmodule

bind multi_shape_lfo_core mslfo_checker u_mslfo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/lfo_checker.sv
// ----------------------------------------------------------------------------
// lfo_checker
// Watches the config port and both stream channels of the multi-shape LFO.
// It keeps its own copy of phase, random values and registers. It predicts
// each tick's sample and compares results in order, field by field.
// ----------------------------------------------------------------------------
module lfo_checker #(
  parameter int SINE_TABLE_DEPTH = mslfo_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mslfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mslfo_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [mslfo_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [mslfo_pkg::SAMPLE_W-1:0]  m_tdata,
  input  logic                            m_tuser,
  output int                              mismatch_count,
  output int                              in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  import mslfo_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic        wrapped;
  } lfo_sample_t;

  int          sine_rom [SINE_TABLE_DEPTH];
  logic [2:0]  shape;
  logic [31:0] phase_step;
  logic [15:0] depth;
  logic [31:0] phase;
  int          held_rand;
  int          next_rand;
  lfo_sample_t expected_samples [$];

  // quarter-wave table from a Q30 Taylor series
  initial begin
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] entry;
    mismatch_count = 0;
    in_flight = 0;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * (2 * i + 1)) / (2 * SINE_TABLE_DEPTH);
      term = x;
      sum = x;
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      entry = (sum * 32768 + (64'd1 << 29)) >> 30;
      if (entry > 32768) begin
        entry = 32768;
      end
      sine_rom[i] = int'(entry);
    end
  end

  function automatic int shape_value();
    logic [1:0]  quad;
    longint      idx;
    longint      prod;
    logic [31:0] tri_gap;
    int          s;
    case (shape)
      SHAPE_SINE: begin
        quad = phase[31:30];
        idx = ({34'd0, phase[29:0]} * SINE_TABLE_DEPTH) >> 30;
        if (idx >= SINE_TABLE_DEPTH) begin
          idx = SINE_TABLE_DEPTH - 1;
        end
        if (quad[0]) begin
          idx = SINE_TABLE_DEPTH - 1 - idx;
        end
        s = sine_rom[idx];
        return quad[1] ? -s : s;
      end
      SHAPE_SQUARE: return phase[31] ? -32768 : 32768;
      SHAPE_RANDOM: begin
        prod = longint'(next_rand - held_rand) * longint'({32'd0, phase});
        return held_rand + int'(prod >>> 32);
      end
      SHAPE_TRIANGLE: begin
        tri_gap = phase[31] ? phase - 32'h8000_0000 : 32'h8000_0000 - phase;
        return 32768 - int'(tri_gap >> 15);
      end
      default: return 0;
    endcase
  endfunction

  // sample for the current phase, then step the phase
  function automatic lfo_sample_t advance_lfo(input logic [15:0] fresh);
    longint      scaled;
    logic [32:0] total;
    lfo_sample_t r;
    scaled = (longint'(shape_value()) * longint'({48'd0, depth}) + 16384) >>> 15;
    if (scaled > 32767) begin
      scaled = 32767;
    end
    if (scaled < -32768) begin
      scaled = -32768;
    end
    r.value = scaled[15:0];
    total = {1'b0, phase} + {1'b0, phase_step};
    r.wrapped = total[32];
    phase = total[31:0];
    if (r.wrapped) begin
      held_rand = next_rand;
      next_rand = int'($signed(fresh));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    lfo_sample_t want;
    if (rst) begin
      shape = SHAPE_SINE;
      phase_step = '0;
      depth = DEPTH_RESET;
      phase = '0;
      held_rand = 0;
      next_rand = 0;
      expected_samples.delete();
      in_flight <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SHAPE: shape = cfg_data[2:0];
          REG_INC:   phase_step = cfg_data;
          REG_DEPTH: depth = cfg_data[15:0];
          default:   ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_NOTE) begin
          phase = s_tdata[31:0];
          held_rand = int'($signed(s_tdata[47:32]));
          next_rand = int'($signed(s_tdata[63:48]));
        end else begin
          expected_samples.push_back(advance_lfo(s_tdata[63:48]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("beat with none expected", int'($signed(m_tdata)), 0);
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want.value) begin
            report_mismatch("lfo_value", int'($signed(m_tdata)), int'($signed(want.value)));
          end
          if (m_tuser !== want.wrapped) begin
            report_mismatch("phase_wrapped", int'(m_tuser), int'(want.wrapped));
          end
        end
      end
      in_flight <= expected_samples.size();
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for multi_shape_lfo_core: directed beats over every shape code and
// the field extremes, then random phases of ticks and note starts under
// changing configs, with random idle bursts on both channels, one long
// receiver hold-off and one sender pause. Checking is done by lfo_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mslfo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_CYCLES = 200;
  localparam int SETTLE_CYCLES = 16;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_tdata;
  logic                 m_tuser;
  int                   mismatches;
  int                   in_flight;
  bit                   idling = 1'b1;
  bit                   long_stall_req = 1'b0;

  always #2 clk = ~clk;

  multi_shape_lfo_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  lfo_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatches),
    .in_flight      (in_flight)
  );

  task automatic configure(input logic [2:0] shape, input logic [31:0] inc,
                           input logic [15:0] depth);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SHAPE;
    cfg_data <= {29'd0, shape};
    @(posedge clk);
    cfg_index <= REG_INC;
    cfg_data <= inc;
    @(posedge clk);
    cfg_index <= REG_DEPTH;
    cfg_data <= {16'd0, depth};
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_index <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_beat(input logic op, input logic [31:0] start_phase,
                           input logic [15:0] first, input logic [15:0] fresh);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {fresh, first, start_phase};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] dir_inc [8] = '{32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'h4000_0000,
                                 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000};
    logic [15:0] dir_depth [8] = '{16'd32768, 16'd65535, 16'd32768, 16'd65535,
                                   16'd32768, 16'd0, 16'd12345, 16'd32768};
    logic [31:0] dir_phase [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h3FFF_FFFF, 32'hC000_0000, 32'h7FFF_FFFF, 32'h4000_0000};
    logic [2:0]  shape_sel;
    logic [31:0] inc_sel;
    logic [15:0] depth_sel;
    logic        op;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: sine, zero step, unity depth
    send_beat(OP_TICK, $urandom, 16'($urandom), 16'($urandom));
    send_beat(OP_TICK, $urandom, 16'($urandom), 16'($urandom));

    for (int s = 0; s < 8; s++) begin
      drain(SETTLE_CYCLES);
      configure(3'(s), dir_inc[s], dir_depth[s]);
      send_beat(OP_NOTE, dir_phase[s], s[0] ? 16'h7FFF : 16'h8000,
                s[0] ? 16'h8000 : 16'h7FFF);
      send_beat(OP_TICK, $urandom, 16'($urandom), s[1] ? 16'h7FFF : 16'h8000);
      send_beat(OP_TICK, $urandom, 16'($urandom), 16'($urandom));
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain(SETTLE_CYCLES);
      idling = (ph < 10) && (ph != 7);
      shape_sel = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       inc_sel = 32'h0000_0000;
        1:       inc_sel = 32'hFFFF_FFFF;
        2:       inc_sel = $urandom;
        default: inc_sel = $urandom_range(32'h0100_0000, 32'h2000_0000);
      endcase
      case ($urandom_range(0, 5))
        0:       depth_sel = 16'd0;
        1:       depth_sel = 16'd32768;
        2:       depth_sel = 16'hFFFF;
        default: depth_sel = 16'($urandom_range(0, 32768));
      endcase
      configure(shape_sel, inc_sel, depth_sel);
      if (ph == 3) begin
        long_stall_req = 1'b1;
      end
      for (int n = 0; n < 50; n++) begin
        if (ph == 5 && n == 25) begin
          drain(0);
        end
        op = ($urandom_range(0, 11) == 0) ? OP_NOTE : OP_TICK;
        send_beat(op, $urandom, 16'($urandom), 16'($urandom));
      end
    end

    drain(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mslfo_pkg.sv
hdl/mslfo_sine_rom.sv
hdl/mslfo_mul.sv
hdl/multi_shape_lfo_core.sv
hdl/mslfo_checker.sv
test/lfo_checker.sv
test/testbench.sv
